// ===== src/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers that compile away when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_ON_CLK(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");

`define ASSERT_NO_RST(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("assertion failed");

`else

`define ASSERT_ON_CLK(label, clk, rst, prop)

`define ASSERT_NO_RST(label, clk, prop)

`endif

`endif

// ===== src/spp_pkg.sv =====
// ----------------------------------------------------------------------------
// Smith predictor PI step package
// Widths, register codes, shared types and saturation helpers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package spp_pkg;

   localparam int SIG_W       = 32;
   localparam int EXT_W       = SIG_W + 1;
   localparam int FRAC_W      = 16;
   localparam int DELAY_W     = 6;
   localparam int GAIN_W      = 31;
   localparam int CSR_IDX_W   = 3;
   localparam int DELAY_DEPTH = 64;
   localparam int RING_AW     = $clog2(DELAY_DEPTH);
   localparam int MAC_OP_W    = SIG_W + 1;
   localparam int PROD_W      = 2 * MAC_OP_W;
   localparam int ACC_W       = PROD_W + 2;

   localparam logic signed [SIG_W-1:0] SIG_MAX = {1'b0, {(SIG_W-1){1'b1}}};
   localparam logic signed [SIG_W-1:0] SIG_MIN = {1'b1, {(SIG_W-1){1'b0}}};
   localparam logic signed [SIG_W-1:0] DRIVE_MAX_RESET = SIG_W'(1) << FRAC_W;
   localparam logic [DELAY_W-1:0] DELAY_RESET = DELAY_W'(1);
   localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(1) << (FRAC_W - 1);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_MODEL_A1   = 3'd0,
      CSR_MODEL_B0   = 3'd1,
      CSR_MODEL_B1   = 3'd2,
      CSR_DELAY      = 3'd3,
      CSR_PROP_GAIN  = 3'd4,
      CSR_INT_GAIN   = 3'd5,
      CSR_DRIVE_MIN  = 3'd6,
      CSR_DRIVE_MAX  = 3'd7
   } csr_idx_type;

   typedef enum logic [1:0] {
      ACC_HOLD,
      ACC_LOAD,
      ACC_ADD
   } acc_op_type;

   typedef struct packed {
      logic signed [MAC_OP_W-1:0] op_a;
      logic signed [MAC_OP_W-1:0] op_b;
      acc_op_type                 acc_op;
   } mac_ctrl_type;

   typedef struct packed {
      logic                    we;
      logic [RING_AW-1:0]      waddr;
      logic signed [SIG_W-1:0] wdata;
      logic                    re;
      logic [RING_AW-1:0]      raddr;
   } ring_cmd_type;

   function automatic logic signed [SIG_W-1:0] sat_wide(input logic signed [EXT_W-1:0] v);
      logic signed [SIG_W-1:0] r;
      if (v[EXT_W-1] != v[SIG_W-1]) begin
         r = v[EXT_W-1] ? SIG_MIN : SIG_MAX;
      end else begin
         r = v[SIG_W-1:0];
      end
      return r;
   endfunction

   function automatic logic signed [SIG_W-1:0] sat_sum(input logic signed [SIG_W-1:0] a,
                                                        input logic signed [SIG_W-1:0] b);
      logic signed [EXT_W-1:0] s;
      s = EXT_W'(a) + EXT_W'(b);
      return sat_wide(s);
   endfunction

   function automatic logic signed [SIG_W-1:0] sat_diff(input logic signed [SIG_W-1:0] a,
                                                         input logic signed [SIG_W-1:0] b);
      logic signed [EXT_W-1:0] s;
      s = EXT_W'(a) - EXT_W'(b);
      return sat_wide(s);
   endfunction

endpackage

// ===== src/spp_req_if.sv =====
// ----------------------------------------------------------------------------
// Sample request channel
// Valid/ready channel that carries the setpoint and the measured value.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface spp_req_if;

   logic                             valid;
   logic                             ready;
   logic signed [spp_pkg::SIG_W-1:0] target;
   logic signed [spp_pkg::SIG_W-1:0] measured;

   modport source (output valid, output target, output measured, input ready);
   modport sink (input valid, input target, input measured, output ready);

endinterface

// ===== src/spp_rsp_if.sv =====
// ----------------------------------------------------------------------------
// Controller response channel
// Valid/ready channel that carries the drive, clamp flag and model outputs.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface spp_rsp_if;

   logic                             valid;
   logic                             ready;
   logic signed [spp_pkg::SIG_W-1:0] drive;
   logic                             limited;
   logic signed [spp_pkg::SIG_W-1:0] model_prediction;
   logic signed [spp_pkg::SIG_W-1:0] model_mismatch;

   modport source (output valid, output drive, output limited, output model_prediction,
                   output model_mismatch, input ready);
   modport sink (input valid, input drive, input limited, input model_prediction,
                 input model_mismatch, output ready);

endinterface

// ===== src/spp_mac.sv =====
// ----------------------------------------------------------------------------
// Shared multiply-accumulate unit
// Registered signed multiplier feeding an exact accumulator; the result is
// the accumulated sum rounded half up to Q16.16 and saturated.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module spp_mac (
   input  logic                             clock,
   input  spp_pkg::mac_ctrl_type            ctrl,
   output logic signed [spp_pkg::SIG_W-1:0] result
);

   logic signed [spp_pkg::PROD_W-1:0] prod_ff;
   logic signed [spp_pkg::ACC_W-1:0]  acc_ff;
   logic signed [spp_pkg::ACC_W-1:0]  shifted;
   logic [spp_pkg::ACC_W-spp_pkg::SIG_W:0] hi_bits;

   always_ff @(posedge clock) begin
      prod_ff <= $signed(ctrl.op_a) * $signed(ctrl.op_b);
      case (ctrl.acc_op)
         spp_pkg::ACC_LOAD: begin
            acc_ff <= spp_pkg::ACC_W'(prod_ff) + spp_pkg::ROUND_HALF;
         end
         spp_pkg::ACC_ADD: begin
            acc_ff <= acc_ff + spp_pkg::ACC_W'(prod_ff);
         end
         default: begin
            acc_ff <= acc_ff;
         end
      endcase
   end

   always_comb begin
      shifted = acc_ff >>> spp_pkg::FRAC_W;
      hi_bits = shifted[spp_pkg::ACC_W-1:spp_pkg::SIG_W-1];
      if ((&hi_bits) || !(|hi_bits)) begin
         result = shifted[spp_pkg::SIG_W-1:0];
      end else if (shifted[spp_pkg::ACC_W-1]) begin
         result = spp_pkg::SIG_MIN;
      end else begin
         result = spp_pkg::SIG_MAX;
      end
   end

endmodule

// ===== src/spp_ring.sv =====
// ----------------------------------------------------------------------------
// Model delay line
// Single-port-write, registered-read memory holding past model outputs.
// Entries never written since reset read as zero.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module spp_ring (
   input  logic                             clock,
   input  logic                             reset,
   input  spp_pkg::ring_cmd_type            cmd,
   output logic signed [spp_pkg::SIG_W-1:0] rdata
);

   logic signed [spp_pkg::SIG_W-1:0] ring_mem [spp_pkg::DELAY_DEPTH];
   logic [spp_pkg::DELAY_DEPTH-1:0]  valid_ff;
   logic signed [spp_pkg::SIG_W-1:0] rd_data_ff;
   logic                             rd_valid_ff;

   always_ff @(posedge clock) begin
      if (cmd.we) begin
         ring_mem[cmd.waddr] <= cmd.wdata;
      end
      if (cmd.re) begin
         rd_data_ff <= ring_mem[cmd.raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         if (cmd.we) begin
            valid_ff[cmd.waddr] <= 1'b1;
         end
         if (cmd.re) begin
            rd_valid_ff <= valid_ff[cmd.raddr];
         end
      end
   end

   assign rdata = rd_valid_ff ? rd_data_ff : '0;

endmodule

// ===== src/smith_predictor_pi_step_core.sv =====
// ----------------------------------------------------------------------------
// Smith predictor PI controller step
// A new sample is taken only once the previous response has been loaded into
// the output register, since up to five products (three when prop_gain is
// zero) share the one multiply-accumulate unit.
// Reset (synchronous, active high) restores register defaults and clears the
// model, drive, integral and delay line.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module smith_predictor_pi_step_core (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_we,
   input  logic [spp_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [spp_pkg::SIG_W-1:0]            csr_wdata,
   spp_req_if.sink                              req_if,
   spp_rsp_if.source                            rsp_if
);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_B0,
      ST_B1,
      ST_MACC,
      ST_MODEL,
      ST_READ,
      ST_FB,
      ST_YFB,
      ST_ERR,
      ST_PMUL,
      ST_IMUL,
      ST_PROP,
      ST_INT,
      ST_RAW,
      ST_OUT
   } state_type;

   logic signed [spp_pkg::SIG_W-1:0]  a1_ff;
   logic signed [spp_pkg::SIG_W-1:0]  b0_ff;
   logic signed [spp_pkg::SIG_W-1:0]  b1_ff;
   logic [spp_pkg::DELAY_W-1:0]       delay_ff;
   logic [spp_pkg::GAIN_W-1:0]        kp_ff;
   logic [spp_pkg::GAIN_W-1:0]        ki_ff;
   logic signed [spp_pkg::SIG_W-1:0]  drive_min_ff;
   logic signed [spp_pkg::SIG_W-1:0]  drive_max_ff;

   state_type                         state_ff;
   logic signed [spp_pkg::SIG_W-1:0]  target_ff;
   logic signed [spp_pkg::SIG_W-1:0]  measured_ff;
   logic signed [spp_pkg::SIG_W-1:0]  model_ff;
   logic signed [spp_pkg::SIG_W-1:0]  last_drive_ff;
   logic signed [spp_pkg::SIG_W-1:0]  integral_ff;
   logic [spp_pkg::RING_AW-1:0]       head_ff;
   logic signed [spp_pkg::SIG_W-1:0]  mismatch_ff;
   logic signed [spp_pkg::SIG_W-1:0]  err_ff;
   logic signed [spp_pkg::SIG_W-1:0]  prop_ff;
   logic signed [spp_pkg::SIG_W-1:0]  raw_ff;
   logic                              rsp_valid_ff;
   logic signed [spp_pkg::SIG_W-1:0]  rsp_drive_ff;
   logic                              rsp_limited_ff;
   logic signed [spp_pkg::SIG_W-1:0]  rsp_pred_ff;
   logic signed [spp_pkg::SIG_W-1:0]  rsp_mismatch_ff;

   logic                              req_fire;
   spp_pkg::mac_ctrl_type             mac_ctrl;
   logic signed [spp_pkg::SIG_W-1:0]  mac_result;
   spp_pkg::ring_cmd_type             ring_cmd;
   logic signed [spp_pkg::SIG_W-1:0]  ring_rdata;
   logic signed [spp_pkg::SIG_W-1:0]  clamped;
   logic                              clamp_hit;

   spp_mac u_mac (
      .clock  (clock),
      .ctrl   (mac_ctrl),
      .result (mac_result)
   );

   spp_ring u_ring (
      .clock (clock),
      .reset (reset),
      .cmd   (ring_cmd),
      .rdata (ring_rdata)
   );

   assign req_if.ready            = (state_ff == ST_IDLE);
   assign req_fire                = req_if.valid && req_if.ready;
   assign rsp_if.valid            = rsp_valid_ff;
   assign rsp_if.drive            = rsp_drive_ff;
   assign rsp_if.limited          = rsp_limited_ff;
   assign rsp_if.model_prediction = rsp_pred_ff;
   assign rsp_if.model_mismatch   = rsp_mismatch_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         a1_ff        <= '0;
         b0_ff        <= '0;
         b1_ff        <= '0;
         delay_ff     <= spp_pkg::DELAY_RESET;
         kp_ff        <= '0;
         ki_ff        <= '0;
         drive_min_ff <= '0;
         drive_max_ff <= spp_pkg::DRIVE_MAX_RESET;
      end else if (csr_we) begin
         case (spp_pkg::csr_idx_type'(csr_index))
            spp_pkg::CSR_MODEL_A1:  a1_ff        <= csr_wdata;
            spp_pkg::CSR_MODEL_B0:  b0_ff        <= csr_wdata;
            spp_pkg::CSR_MODEL_B1:  b1_ff        <= csr_wdata;
            spp_pkg::CSR_DELAY:     delay_ff     <= csr_wdata[spp_pkg::DELAY_W-1:0];
            spp_pkg::CSR_PROP_GAIN: kp_ff        <= csr_wdata[spp_pkg::GAIN_W-1:0];
            spp_pkg::CSR_INT_GAIN:  ki_ff        <= csr_wdata[spp_pkg::GAIN_W-1:0];
            spp_pkg::CSR_DRIVE_MIN: drive_min_ff <= csr_wdata;
            spp_pkg::CSR_DRIVE_MAX: drive_max_ff <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      mac_ctrl.op_a   = '0;
      mac_ctrl.op_b   = '0;
      mac_ctrl.acc_op = spp_pkg::ACC_HOLD;
      case (state_ff)
         ST_IDLE: begin
            mac_ctrl.op_a = spp_pkg::MAC_OP_W'(a1_ff);
            mac_ctrl.op_b = spp_pkg::MAC_OP_W'(model_ff);
         end
         ST_B0: begin
            mac_ctrl.op_a   = spp_pkg::MAC_OP_W'(b0_ff);
            mac_ctrl.op_b   = spp_pkg::MAC_OP_W'(last_drive_ff);
            mac_ctrl.acc_op = spp_pkg::ACC_LOAD;
         end
         ST_B1: begin
            mac_ctrl.op_a   = spp_pkg::MAC_OP_W'(b1_ff);
            mac_ctrl.op_b   = spp_pkg::MAC_OP_W'(last_drive_ff);
            mac_ctrl.acc_op = spp_pkg::ACC_ADD;
         end
         ST_MACC: begin
            mac_ctrl.acc_op = spp_pkg::ACC_ADD;
         end
         ST_PMUL: begin
            mac_ctrl.op_a = spp_pkg::MAC_OP_W'(kp_ff);
            mac_ctrl.op_b = spp_pkg::MAC_OP_W'(err_ff);
         end
         ST_IMUL: begin
            mac_ctrl.op_a   = spp_pkg::MAC_OP_W'(ki_ff);
            mac_ctrl.op_b   = spp_pkg::MAC_OP_W'(err_ff);
            mac_ctrl.acc_op = spp_pkg::ACC_LOAD;
         end
         ST_PROP: begin
            mac_ctrl.acc_op = spp_pkg::ACC_LOAD;
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      ring_cmd.we    = (state_ff == ST_MODEL);
      ring_cmd.waddr = head_ff + spp_pkg::RING_AW'(1);
      ring_cmd.wdata = mac_result;
      ring_cmd.re    = (state_ff == ST_READ);
      ring_cmd.raddr = head_ff - spp_pkg::RING_AW'(delay_ff);
   end

   // drive_max is tested first, so it wins when raw is past both limits.
   always_comb begin
      if (raw_ff > drive_max_ff) begin
         clamped   = drive_max_ff;
         clamp_hit = 1'b1;
      end else if (raw_ff < drive_min_ff) begin
         clamped   = drive_min_ff;
         clamp_hit = 1'b1;
      end else begin
         clamped   = raw_ff;
         clamp_hit = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         rsp_valid_ff  <= 1'b0;
         model_ff      <= '0;
         last_drive_ff <= '0;
         integral_ff   <= '0;
         head_ff       <= '0;
      end else begin
         if (rsp_if.ready && (state_ff != ST_OUT)) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (req_fire) begin
                  target_ff   <= req_if.target;
                  measured_ff <= req_if.measured;
                  state_ff    <= ST_B0;
               end
            end
            ST_B0: begin
               state_ff <= ST_B1;
            end
            ST_B1: begin
               state_ff <= ST_MACC;
            end
            ST_MACC: begin
               state_ff <= ST_MODEL;
            end
            ST_MODEL: begin
               model_ff <= mac_result;
               head_ff  <= head_ff + spp_pkg::RING_AW'(1);
               state_ff <= ST_READ;
            end
            ST_READ: begin
               state_ff <= ST_FB;
            end
            ST_FB: begin
               mismatch_ff <= spp_pkg::sat_diff(measured_ff, ring_rdata);
               state_ff    <= ST_YFB;
            end
            ST_YFB: begin
               err_ff   <= spp_pkg::sat_sum(model_ff, mismatch_ff);
               state_ff <= ST_ERR;
            end
            ST_ERR: begin
               err_ff   <= spp_pkg::sat_diff(target_ff, err_ff);
               state_ff <= (kp_ff == '0) ? ST_RAW : ST_PMUL;
            end
            ST_PMUL: begin
               state_ff <= ST_IMUL;
            end
            ST_IMUL: begin
               state_ff <= ST_PROP;
            end
            ST_PROP: begin
               prop_ff  <= mac_result;
               state_ff <= ST_INT;
            end
            ST_INT: begin
               if (ki_ff != '0) begin
                  integral_ff <= spp_pkg::sat_sum(integral_ff, mac_result);
               end
               state_ff <= ST_RAW;
            end
            ST_RAW: begin
               raw_ff   <= (kp_ff == '0) ? '0 : spp_pkg::sat_sum(prop_ff, integral_ff);
               state_ff <= ST_OUT;
            end
            ST_OUT: begin
               if (!rsp_valid_ff || rsp_if.ready) begin
                  rsp_valid_ff    <= 1'b1;
                  rsp_drive_ff    <= clamped;
                  rsp_limited_ff  <= clamp_hit;
                  rsp_pred_ff     <= model_ff;
                  rsp_mismatch_ff <= mismatch_ff;
                  last_drive_ff   <= clamped;
                  state_ff        <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   `ASSERT_ON_CLK(a_accept_starts_model, clock, reset, req_fire |=> state_ff == ST_B0)
   `ASSERT_ON_CLK(a_head_steps_once, clock, reset, (state_ff == ST_MODEL) |=> (head_ff == ($past(head_ff) + spp_pkg::RING_AW'(1))))
   `ASSERT_ON_CLK(a_integral_only_in_int, clock, reset, (state_ff != ST_INT) |=> $stable(integral_ff))
   `ASSERT_ON_CLK(a_rsp_from_out, clock, reset, $rose(rsp_valid_ff) |-> $past(state_ff == ST_OUT))

endmodule
